>>> src/xcpr_pkg.sv
// Package for the XCP slave command responder.
// Holds the opcodes, response codes, preset image rows and shared helpers.
// No dependencies.
`default_nettype none

package xcpr_pkg;

  // Command opcodes (packet byte 0).
  localparam logic [7:0] CMD_CONNECT    = 8'hFF;
  localparam logic [7:0] CMD_STATUS_REQ = 8'hFD;
  localparam logic [7:0] CMD_GET_ID     = 8'hFA;
  localparam logic [7:0] CMD_SET_MTA    = 8'hF6;
  localparam logic [7:0] CMD_UPLOAD     = 8'hF5;

  // Response packet identifiers and error code.
  localparam logic [7:0] PID_RES          = 8'hFF;
  localparam logic [7:0] PID_ERR          = 8'hFE;
  localparam logic [7:0] ERR_CMD_UNKNOWN  = 8'h20;
  localparam logic [7:0] ID_MODE_INLINE   = 8'h01;

  // Configuration register indexes.
  localparam logic [1:0] REG_CONNECT_INFO = 2'd0;
  localparam logic [1:0] REG_STATUS_INFO  = 2'd1;
  localparam logic [1:0] REG_ID_LENGTH    = 2'd2;
  localparam logic [1:0] REG_ID_BYTES     = 2'd3;

  // Memory is organized as 8-byte rows; a 32-bit byte address has a 29-bit row.
  localparam int ROW_ADDR_W = 29;
  localparam int ROW_SEL_W  = 13;

  // Preset contents of the image: bytes 0 to 13, the rest zero.
  localparam logic [63:0] PRESET_ROW0 = 64'h1234_5678_0000_0C8A;
  localparam logic [63:0] PRESET_ROW1 = 64'h036B_416B_3333_0000;

  typedef struct packed {
    logic                  en;
    logic [ROW_ADDR_W-1:0] row;
  } rd_req_t;

  function automatic logic [63:0] preset_row(input logic [ROW_SEL_W-1:0] row);
    logic [63:0] val;
    case (row)
      13'd0:   val = PRESET_ROW0;
      13'd1:   val = PRESET_ROW1;
      default: val = 64'h0;
    endcase
    return val;
  endfunction

  // Mask that keeps the first n bytes of a word, first byte in bits 63 to 56.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = 64'h0;
    for (int i = 0; i < 8; i++) begin
      if (n > 4'(i)) begin
        m[63 - 8*i -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/xcp_slave_command_responder.sv
// XCP slave command responder. A register-sourced response (CONNECT, status,
// GET_ID, SET_MTA, errors) passes the byte buffer (S_BUF) and then the output
// register; UPLOAD passes S_UPA, S_UPB and S_UPC before the output register.
// Words then leave one a cycle while the receiver is ready. UPLOAD of size bytes
// gives ceil((size+1)/8) words, paced by the one 64-bit read port.
// While the image load runs after reset, in_ready is low.
`default_nettype none

module xcp_slave_command_responder #(
  parameter int MEM_BYTES    = 256,
  parameter int ID_MAX_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_req_type,
  input  wire logic [3:0]  in_packet_len,
  input  wire logic [7:0]  in_arg_byte,
  input  wire logic [31:0] in_address,
  // Response channel, one 8-byte word per handshake.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_resp_data,
  output logic [3:0]       out_resp_bytes,
  output logic             out_resp_last,
  // Configuration writes.
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wr_data
);

  // The image is held in 8-byte rows; the last row is padded with zero bytes.
  localparam int MEM_ROWS = (MEM_BYTES + 7) / 8;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,  // image load sweep running
    S_IDLE = 6'b000010,  // waiting for a command
    S_BUF  = 6'b000100,  // sending a response held in the byte buffer
    S_UPA  = 6'b001000,  // UPLOAD: read the first row
    S_UPB  = 6'b010000,  // UPLOAD: read the second row
    S_UPC  = 6'b100000   // UPLOAD: one word per cycle from two rows while the output slot is free
  } state_t;

  // Configuration registers.
  logic [55:0] connect_info_r;
  logic [31:0] status_info_r;
  logic [3:0]  id_length_r;
  logic [63:0] id_bytes_r;

  // Control state.
  state_t      state_r, state_nxt;
  logic [31:0] mta_r, mta_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic        first_r, first_nxt;
  logic [xcpr_pkg::ROW_ADDR_W-1:0] rd_row_r, rd_row_nxt;
  logic [2:0]  off_r, off_nxt;
  logic        out_valid_r;

  // Payload state.
  logic [127:0] buf_r, buf_nxt;
  logic [63:0]  prev_r, prev_nxt;
  logic [63:0]  out_data_r;
  logic [3:0]   out_bytes_r;
  logic         out_last_r;

  xcpr_pkg::rd_req_t rd_req;
  logic [63:0]       rd_data;
  logic              init_done;

  xcpr_row_mem #(
    .MEM_ROWS (MEM_ROWS)
  ) u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rd_req),
    .rd_data   (rd_data),
    .init_done (init_done)
  );

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      connect_info_r <= '0;
      status_info_r  <= '0;
      id_length_r    <= '0;
      id_bytes_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        xcpr_pkg::REG_CONNECT_INFO: connect_info_r <= cfg_wr_data[55:0];
        xcpr_pkg::REG_STATUS_INFO:  status_info_r  <= cfg_wr_data[31:0];
        xcpr_pkg::REG_ID_LENGTH:    id_length_r    <= cfg_wr_data[3:0];
        xcpr_pkg::REG_ID_BYTES:     id_bytes_r     <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode and word assembly
  // ---------------------------------------------------------------------------
  logic        accept;
  logic        slot_free;
  logic        emit;
  logic        pkt_ok;
  logic [3:0]  id_n;
  logic [31:0] v0;
  logic [127:0] row_cat;
  logic [127:0] row_shift;
  logic [63:0] chunk_raw;
  logic [3:0]  chunk_cnt;
  logic        chunk_last;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign emit      = ((state_r == S_BUF) || (state_r == S_UPC)) && slot_free;
  assign pkt_ok    = (in_packet_len != 4'd0);

  // The identifier length is bounded to the configured maximum.
  assign id_n = (id_length_r > 4'(ID_MAX_BYTES)) ? 4'(ID_MAX_BYTES) : id_length_r;

  // Upload words are laid over the byte stream starting one byte before the
  // MTA, so that the leading FF takes that position in the first word.
  assign v0 = mta_r - 32'd1;

  // An upload word straddles at most two rows: prev_r and the current read.
  assign row_cat   = {prev_r, rd_data};
  assign row_shift = row_cat << {off_r, 3'b000};

  always_comb begin
    if (state_r == S_UPC) begin
      if (first_r) begin
        chunk_raw = {xcpr_pkg::PID_RES, row_shift[119:64]};
      end else begin
        chunk_raw = row_shift[127:64];
      end
    end else begin
      chunk_raw = buf_r[127:64];
    end
  end

  assign chunk_last = (rem_r <= 9'd8);
  assign chunk_cnt  = chunk_last ? rem_r[3:0] : 4'd8;

  assign rd_req.en  = (state_r == S_UPA) || (state_r == S_UPB) ||
                      ((state_r == S_UPC) && slot_free);
  assign rd_req.row = rd_row_r;

  always_comb begin
    state_nxt  = state_r;
    mta_nxt    = mta_r;
    rem_nxt    = rem_r;
    first_nxt  = first_r;
    rd_row_nxt = rd_row_r;
    off_nxt    = off_r;
    buf_nxt    = buf_r;
    prev_nxt   = prev_r;

    case (state_r)
      S_INIT: begin
        if (init_done) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          // Error response is the default; each valid command overrides it.
          state_nxt = S_BUF;
          buf_nxt   = {xcpr_pkg::PID_ERR, xcpr_pkg::ERR_CMD_UNKNOWN, 112'h0};
          rem_nxt   = 9'd2;
          if (pkt_ok) begin
            case (in_req_type)
              xcpr_pkg::CMD_CONNECT: begin
                buf_nxt = {xcpr_pkg::PID_RES, connect_info_r, 64'h0};
                rem_nxt = 9'd8;
              end
              xcpr_pkg::CMD_STATUS_REQ: begin
                buf_nxt = {xcpr_pkg::PID_RES, status_info_r, 8'h00, 80'h0};
                rem_nxt = 9'd6;
              end
              xcpr_pkg::CMD_GET_ID: begin
                buf_nxt = {xcpr_pkg::PID_RES, xcpr_pkg::ID_MODE_INLINE, 16'h0000,
                           28'h0, id_n, id_bytes_r & xcpr_pkg::byte_mask(id_n)};
                rem_nxt = 9'd8 + 9'(id_n);
              end
              xcpr_pkg::CMD_SET_MTA: begin
                if (in_packet_len[3]) begin
                  mta_nxt = in_address;
                  buf_nxt = {xcpr_pkg::PID_RES, 120'h0};
                  rem_nxt = 9'd1;
                end
              end
              xcpr_pkg::CMD_UPLOAD: begin
                if (in_packet_len >= 4'd2) begin
                  state_nxt  = S_UPA;
                  rem_nxt    = 9'(in_arg_byte) + 9'd1;
                  first_nxt  = 1'b1;
                  rd_row_nxt = v0[31:3];
                  off_nxt    = v0[2:0];
                  mta_nxt    = mta_r + 32'(in_arg_byte);
                end
              end
              default: ;
            endcase
          end
        end
      end

      S_BUF: begin
        if (emit) begin
          buf_nxt = {buf_r[63:0], 64'h0};
          rem_nxt = rem_r - 9'd8;
          if (chunk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_UPA: begin
        rd_row_nxt = rd_row_r + xcpr_pkg::ROW_ADDR_W'(1);
        state_nxt  = S_UPB;
      end

      S_UPB: begin
        prev_nxt   = rd_data;
        rd_row_nxt = rd_row_r + xcpr_pkg::ROW_ADDR_W'(1);
        state_nxt  = S_UPC;
      end

      S_UPC: begin
        if (emit) begin
          prev_nxt   = rd_data;
          rd_row_nxt = rd_row_r + xcpr_pkg::ROW_ADDR_W'(1);
          first_nxt  = 1'b0;
          rem_nxt    = rem_r - 9'd8;
          if (chunk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      mta_r       <= '0;
      rem_r       <= '0;
      first_r     <= 1'b0;
      rd_row_r    <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mta_r    <= mta_nxt;
      rem_r    <= rem_nxt;
      first_r  <= first_nxt;
      rd_row_r <= rd_row_nxt;
      off_r    <= off_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register; bytes past the word's count are forced to zero.
  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    prev_r <= prev_nxt;
    if (emit) begin
      out_data_r  <= chunk_raw & xcpr_pkg::byte_mask(chunk_cnt);
      out_bytes_r <= chunk_cnt;
      out_last_r  <= chunk_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_resp_data  = out_data_r;
  assign out_resp_bytes = out_bytes_r;
  assign out_resp_last  = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_cmd_during_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> init_done)
    else $error("command accepted before image load finished");

  a_word_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_resp_bytes != 4'd0) && (out_resp_bytes <= 4'd8))
    else $error("response word byte count out of range");

  a_busy_after_inner_word: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !chunk_last) |=> (state_r != S_IDLE))
    else $error("returned to idle before the final word");

  a_set_mta_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == xcpr_pkg::CMD_SET_MTA) && in_packet_len[3])
      |=> (mta_r == $past(in_address)))
    else $error("SET_MTA did not load the transfer address");

  a_upload_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPC) |-> (rem_r != 9'd0))
    else $error("upload streaming with no bytes left");

endmodule

`default_nettype wire

>>> src/xcpr_row_mem.sv
// Row-organized image memory for the XCP slave command responder.
// One 64-bit row per entry, loaded with the preset image by a sweep after reset.
// Depends on xcpr_pkg.
`default_nettype none

module xcpr_row_mem #(
  parameter int MEM_ROWS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire xcpr_pkg::rd_req_t rd_req,
  output logic [63:0]           rd_data,
  output logic                  init_done
);

  localparam int IDX_W = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;

  logic [63:0]      mem [MEM_ROWS];
  logic [IDX_W-1:0] init_row_r;
  logic             init_done_r;
  logic [63:0]      q_r;
  logic             oob_r;

  // Load sweep: one row a cycle until the whole image holds its preset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_row_r  <= '0;
      init_done_r <= 1'b0;
    end else if (!init_done_r) begin
      if (init_row_r == IDX_W'(MEM_ROWS - 1)) begin
        init_done_r <= 1'b1;
      end else begin
        init_row_r <= init_row_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      mem[init_row_r] <= xcpr_pkg::preset_row(xcpr_pkg::ROW_SEL_W'(init_row_r));
    end
  end

  // Registered read; the output holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      q_r   <= mem[rd_req.row[IDX_W-1:0]];
      oob_r <= (rd_req.row >= xcpr_pkg::ROW_ADDR_W'(MEM_ROWS));
    end
  end

  assign rd_data   = oob_r ? 64'h0 : q_r;
  assign init_done = init_done_r;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the XCP slave command responder.
// Depends on xcpr_pkg and xcp_slave_command_responder; reads no files.

module tb_top;

  localparam int IMAGE_BYTES = 256;
  localparam int ID_LIMIT    = 8;

  // Bytes 0 to 13 of the image after reset, first byte in the top bits.
  localparam logic [111:0] PRESET_BYTES = 112'h12345678_00000C8A_036B_416B3333;

  // One response word as it should leave the block.
  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_req_type = 8'h00;
  logic [3:0]  in_packet_len = 4'h0;
  logic [7:0]  in_arg_byte = 8'h00;
  logic [31:0] in_address = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_resp_data;
  logic [3:0]  out_resp_bytes;
  logic        out_resp_last;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_wr_data = 64'h0;

  // Our own copy of the slave state: configuration, MTA and memory image.
  logic [55:0] connect_info;
  logic [31:0] status_info;
  logic [3:0]  id_length;
  logic [63:0] id_bytes;
  logic [31:0] mta;
  logic [7:0]  image [IMAGE_BYTES];

  // Response words still owed by the block, oldest first.
  word_t       expected_words [$];

  // Bytes of the response being predicted.
  logic [7:0]  resp_q [$];

  int          errors = 0;
  int          commands_sent = 0;
  int          uploads_sent = 0;
  int          upload_bytes = 0;
  int          words_checked = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;

  xcp_slave_command_responder #(
    .MEM_BYTES   (IMAGE_BYTES),
    .ID_MAX_BYTES(ID_LIMIT)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_packet_len (in_packet_len),
    .in_arg_byte   (in_arg_byte),
    .in_address    (in_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_resp_data (out_resp_data),
    .out_resp_bytes(out_resp_bytes),
    .out_resp_last (out_resp_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // The receiver periodically redraws its stall pattern. It is either always
  // ready, randomly ready, ready three quarters of the time, or ready only in
  // the first third of a repeating window, so long uploads see back-pressure.
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 97 == 0) begin
      rx_mode <= $urandom_range(0, 3);
    end
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (rx_cycle % 4) != 3;
      end
      default: begin
        out_ready <= (rx_cycle % 12) < 4;
      end
    endcase
  end

  // Every word that leaves the block is matched against the oldest expected
  // word. A word with nothing expected is a failure in its own right.
  always @(posedge clk) begin : check_words
    word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word data=%h bytes=%0d last=%b", $time,
                 out_resp_data, out_resp_bytes, out_resp_last);
        errors++;
      end else begin
        w = expected_words.pop_front();
        words_checked++;
        if (out_resp_data !== w.data) begin
          $display("%0t: resp_data expected %h got %h", $time, w.data, out_resp_data);
          errors++;
        end
        if (out_resp_bytes !== w.nbytes) begin
          $display("%0t: resp_bytes expected %0d got %0d", $time, w.nbytes,
                   out_resp_bytes);
          errors++;
        end
        if (out_resp_last !== w.last) begin
          $display("%0t: resp_last expected %b got %b", $time, w.last, out_resp_last);
          errors++;
        end
      end
    end
  end

  // Appends one byte to the response being predicted.
  function automatic void add_resp_byte(input logic [7:0] b);
    resp_q = {resp_q, b};
  endfunction

  // Puts the model state back to what the block holds after reset.
  task automatic reset_slave_state();
    int i;
    connect_info = '0;
    status_info  = '0;
    id_length    = '0;
    id_bytes     = '0;
    mta          = '0;
    for (i = 0; i < IMAGE_BYTES; i++) begin
      image[i] = (i < 14) ? PRESET_BYTES[111 - 8*i -: 8] : 8'h00;
    end
  endtask

  // Builds the response bytes of one command, updates the MTA, and splits the
  // response into 8-byte words on the expected queue.
  task automatic predict_response(input logic [7:0] op, input logic [3:0] plen_in,
                                  input logic [7:0] size, input logic [31:0] addr);
    logic [31:0] a;
    int          plen;
    int          n;
    int          nwords;
    int          cnt;
    int          i;
    int          k;
    word_t       w;
    resp_q.delete();
    plen = (plen_in > 8) ? 8 : plen_in;
    if (plen == 0) begin
      add_resp_byte(xcpr_pkg::PID_ERR);
      add_resp_byte(xcpr_pkg::ERR_CMD_UNKNOWN);
    end else begin
      case (op)
        xcpr_pkg::CMD_CONNECT: begin
          add_resp_byte(xcpr_pkg::PID_RES);
          for (i = 6; i >= 0; i--) add_resp_byte(connect_info[8*i +: 8]);
        end
        xcpr_pkg::CMD_STATUS_REQ: begin
          add_resp_byte(xcpr_pkg::PID_RES);
          for (i = 3; i >= 0; i--) add_resp_byte(status_info[8*i +: 8]);
          add_resp_byte(8'h00);
        end
        xcpr_pkg::CMD_GET_ID: begin
          // Lengths beyond the identifier buffer are clipped everywhere.
          n = (id_length > ID_LIMIT) ? ID_LIMIT : id_length;
          add_resp_byte(xcpr_pkg::PID_RES);
          add_resp_byte(xcpr_pkg::ID_MODE_INLINE);
          add_resp_byte(8'h00);
          add_resp_byte(8'h00);
          add_resp_byte(8'h00);
          add_resp_byte(8'h00);
          add_resp_byte(8'h00);
          add_resp_byte(8'(n));
          for (i = 0; i < n; i++) add_resp_byte(id_bytes[63 - 8*i -: 8]);
        end
        xcpr_pkg::CMD_SET_MTA: begin
          if (plen < 8) begin
            add_resp_byte(xcpr_pkg::PID_ERR);
            add_resp_byte(xcpr_pkg::ERR_CMD_UNKNOWN);
          end else begin
            mta = addr;
            add_resp_byte(xcpr_pkg::PID_RES);
          end
        end
        xcpr_pkg::CMD_UPLOAD: begin
          if (plen < 2) begin
            add_resp_byte(xcpr_pkg::PID_ERR);
            add_resp_byte(xcpr_pkg::ERR_CMD_UNKNOWN);
          end else begin
            add_resp_byte(xcpr_pkg::PID_RES);
            // Each byte address wraps at 32 bits; past the image reads zero.
            for (i = 0; i < size; i++) begin
              a = mta + 32'(i);
              add_resp_byte((a < IMAGE_BYTES) ? image[a[7:0]] : 8'h00);
            end
            mta = mta + 32'(size);
            uploads_sent++;
            upload_bytes += size;
          end
        end
        default: begin
          add_resp_byte(xcpr_pkg::PID_ERR);
          add_resp_byte(xcpr_pkg::ERR_CMD_UNKNOWN);
        end
      endcase
    end
    nwords = (resp_q.size() + 7) / 8;
    for (k = 0; k < nwords; k++) begin
      cnt = resp_q.size() - 8*k;
      if (cnt > 8) cnt = 8;
      w.data = '0;
      for (i = 0; i < cnt; i++) w.data[63 - 8*i -: 8] = resp_q[8*k + i];
      w.nbytes = 4'(cnt);
      w.last   = (k == nwords - 1);
      expected_words = {expected_words, w};
    end
    commands_sent++;
  endtask

  // Sends one command word. Commands go out in bursts of random length; ahead
  // of each burst the sender may drop valid for a random gap. Within a burst
  // valid stays high and only the payload changes after each acceptance.
  task automatic send_command(input logic [7:0] op, input logic [3:0] plen,
                              input logic [7:0] arg, input logic [31:0] addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_packet_len <= plen;
    in_arg_byte   <= arg;
    in_address    <= addr;
    do @(posedge clk); while (!in_ready);
    predict_response(op, plen, arg, addr);
  endtask

  // Holds the sender off until every owed word has come back.
  task automatic drain_responses();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (expected_words.size() == 0);
    @(negedge clk);
  endtask

  // One register write; the model takes the value with the register's width.
  task automatic write_register(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    case (idx)
      xcpr_pkg::REG_CONNECT_INFO: connect_info = val[55:0];
      xcpr_pkg::REG_STATUS_INFO:  status_info  = val[31:0];
      xcpr_pkg::REG_ID_LENGTH:    id_length    = val[3:0];
      xcpr_pkg::REG_ID_BYTES:     id_bytes     = val;
      default:                    ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all_registers(input logic [63:0] conn, input logic [63:0] stat,
                                     input logic [63:0] idlen, input logic [63:0] idb);
    write_register(xcpr_pkg::REG_CONNECT_INFO, conn);
    write_register(xcpr_pkg::REG_STATUS_INFO, stat);
    write_register(xcpr_pkg::REG_ID_LENGTH, idlen);
    write_register(xcpr_pkg::REG_ID_BYTES, idb);
  endtask

  // Straight out of reset: zero registers, zero MTA and the preset image.
  task automatic test_reset_defaults();
    send_command(xcpr_pkg::CMD_CONNECT, 4'd1, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_GET_ID, 4'd1, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd2, 8'd14, 32'h0);
    drain_responses();
  endtask

  // CONNECT, status and GET_ID under extreme and patterned settings,
  // including an identifier length past the buffer limit.
  task automatic test_register_replies();
    write_all_registers({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
    send_command(xcpr_pkg::CMD_CONNECT, 4'd1, 8'hFF, 32'hFFFF_FFFF);
    send_command(xcpr_pkg::CMD_STATUS_REQ, 4'd8, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_GET_ID, 4'd2, 8'h5A, 32'h0);
    drain_responses();
    write_all_registers(64'h00_0102_0304_0506_07, 64'h8000_0001, 64'd8,
                        64'h0123_4567_89AB_CDEF);
    send_command(xcpr_pkg::CMD_GET_ID, 4'd15, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_CONNECT, 4'd9, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_STATUS_REQ, 4'd1, 8'h00, 32'h0);
    drain_responses();
    write_register(xcpr_pkg::REG_ID_LENGTH, 64'd1);
    send_command(xcpr_pkg::CMD_GET_ID, 4'd1, 8'h00, 32'h0);
    drain_responses();
    write_register(xcpr_pkg::REG_ID_LENGTH, 64'd9);
    send_command(xcpr_pkg::CMD_GET_ID, 4'd1, 8'h00, 32'h0);
    drain_responses();
    write_all_registers(64'h0, 64'h0, 64'h0, 64'h0);
    send_command(xcpr_pkg::CMD_GET_ID, 4'd1, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_STATUS_REQ, 4'd1, 8'h00, 32'h0);
    drain_responses();
  endtask

  // Empty packet, unknown opcode and short SET_MTA / UPLOAD packets.
  task automatic test_error_replies();
    send_command(xcpr_pkg::CMD_CONNECT, 4'd0, 8'h00, 32'h0);
    send_command(8'h00, 4'd8, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_SET_MTA, 4'd7, 8'h00, 32'h0000_0040);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd1, 8'd4, 32'h0);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd0, 8'd4, 32'h0);
    drain_responses();
  endtask

  // Uploads across the preset bytes, past the end of the image, across the
  // 32-bit wrap, of size zero, and of the largest size.
  task automatic test_upload_cases();
    send_command(xcpr_pkg::CMD_SET_MTA, 4'd8, 8'h00, 32'h0);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd2, 8'd0, 32'h0);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd2, 8'd14, 32'h0);
    send_command(xcpr_pkg::CMD_SET_MTA, 4'd8, 8'h00, 32'h0000_00FA);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd2, 8'd10, 32'h0);
    send_command(xcpr_pkg::CMD_SET_MTA, 4'd8, 8'h00, 32'hFFFF_FFFC);
    send_command(xcpr_pkg::CMD_UPLOAD, 4'd8, 8'd255, 32'h0);
    drain_responses();
  endtask

  function automatic logic [31:0] pick_mta();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, IMAGE_BYTES - 1);
    if (r < 75) return $urandom_range(IMAGE_BYTES - 16, IMAGE_BYTES + 16);
    if (r < 85) return 32'h0 - 32'($urandom_range(1, 40));
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_upload_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'($urandom_range(128, 255));
    if (r < 15) return 8'd0;
    return 8'($urandom_range(1, 24));
  endfunction

  function automatic logic [63:0] pick_register_value();
    int unsigned r;
    r = $urandom_range(0, 4);
    if (r == 0) return 64'h0;
    if (r == 1) return {64{1'b1}};
    return {$urandom, $urandom};
  endfunction

  // Mostly well-formed SET_MTA plus UPLOAD sequences, interleaved with the
  // register commands, broken packets and random opcodes. Every so many
  // commands the sender waits for all words, then the registers change.
  task automatic test_random_traffic(input int target);
    int start;
    int k;
    int n;
    int unsigned r;
    start = commands_sent;
    while (commands_sent - start < target) begin
      if ((commands_sent - start) % 60 < 2 && commands_sent - start > 2) begin
        drain_responses();
        write_all_registers(pick_register_value(), pick_register_value(),
                            64'($urandom_range(0, 15)), pick_register_value());
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_command(xcpr_pkg::CMD_SET_MTA, 4'($urandom_range(8, 15)), 8'($urandom),
                     pick_mta());
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
          send_command(xcpr_pkg::CMD_UPLOAD, 4'($urandom_range(2, 15)),
                       pick_upload_size(), $urandom);
        end
      end else if (r < 55) begin
        send_command(xcpr_pkg::CMD_UPLOAD, 4'($urandom_range(2, 15)), pick_upload_size(),
                     $urandom);
      end else if (r < 75) begin
        case ($urandom_range(0, 2))
          0:       send_command(xcpr_pkg::CMD_CONNECT, 4'($urandom_range(1, 15)),
                                8'($urandom), $urandom);
          1:       send_command(xcpr_pkg::CMD_STATUS_REQ, 4'($urandom_range(1, 15)),
                                8'($urandom), $urandom);
          default: send_command(xcpr_pkg::CMD_GET_ID, 4'($urandom_range(1, 15)),
                                8'($urandom), $urandom);
        endcase
      end else if (r < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          send_command(xcpr_pkg::CMD_SET_MTA, 4'($urandom_range(0, 7)), 8'($urandom),
                       $urandom);
        end else begin
          send_command(xcpr_pkg::CMD_UPLOAD, 4'($urandom_range(0, 1)), 8'($urandom),
                       $urandom);
        end
      end else begin
        // Noise: any opcode with any length, sizes kept random.
        send_command(8'($urandom), 4'($urandom_range(0, 15)), 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    reset_slave_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_replies();
    test_error_replies();
    test_upload_cases();
    test_random_traffic(345);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    // Leave room for any stray word the block might still emit.
    repeat (40) @(posedge clk);

    $display("Sent %0d commands, %0d of them uploads moving %0d bytes.",
             commands_sent, uploads_sent, upload_bytes);
    $display("Checked %0d response words under varied gaps and back-pressure.",
             words_checked);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
